// ----- hdl/modbus_rtu_read_response_checker_core_assert.svh -----
// Assertion macros for the Modbus RTU read-reply checker.
// Used by the top level only; no other dependencies.
`ifndef MODBUS_RTU_READ_RESPONSE_CHECKER_CORE_ASSERT_SVH
`define MODBUS_RTU_READ_RESPONSE_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RMRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmrc: same-cycle check failed");

// Next-cycle implication.
`define RMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmrc: next-cycle check failed");

`endif

// ----- hdl/rmrc_pkg.sv -----
// Shared types, constants and the CRC-16 byte step for the read-reply checker.
// No dependencies.
package rmrc_pkg;

  localparam int unsigned MAX_REGS_DEF = 32;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] BYTE_MAX   = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME  = 16'd5;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [7:0]  MAX_SLAVE  = 8'd247;
  localparam logic [7:0]  FC_HOLDING = 8'd3;
  localparam logic [7:0]  FC_INPUT   = 8'd4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned WORDS_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE = 2'd0,
    CFG_FUNC  = 2'd1,
    CFG_WORDS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_BAD_CFG   = 3'd1,
    RES_CRC       = 3'd2,
    RES_ADDRESS   = 3'd3,
    RES_FUNCTION  = 3'd4,
    RES_LENGTH    = 3'd5,
    RES_EXCEPTION = 3'd6
  } res_status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept_byte;
    logic clear_frame;
    logic load_status;
    logic load_word;
    logic ram_rd;
    logic idx_clr;
    logic idx_inc;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_ok;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/rmrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmrc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rmrc_dp.sv -----
// Datapath: config registers, frame state, CRC, word store, verdict and output register.
// Depends on rmrc_pkg and rmrc_ram.
module rmrc_dp #(
  parameter int unsigned MAX_REGS = rmrc_pkg::MAX_REGS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rmrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                     rx_byte_i,
  input  rmrc_pkg::ctrl_cmd_t            cmd_i,
  output rmrc_pkg::dp_stat_t             stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [2:0]                     status_o,
  output logic [7:0]                     exc_code_o,
  output logic [4:0]                     word_index_o,
  output logic [15:0]                    word_value_o,
  output logic [5:0]                     word_total_o,
  output logic                           last_o
);
  import rmrc_pkg::*;

  localparam int unsigned AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  // config
  logic [7:0]         slave_q, func_q;
  logic [WORDS_W-1:0] words_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'd1;
      func_q  <= FC_HOLDING;
      words_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SLAVE: slave_q <= cfg_data_i;
        CFG_FUNC:  func_q  <= cfg_data_i;
        CFG_WORDS: words_q <= cfg_data_i[WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [15:0] crc_q, crc_d, rx_crc_q, rx_crc_d, total_q, total_d;
  logic [7:0]  dly0_q, dly0_d, dly1_q, dly1_d, pend_q, pend_d;
  logic [7:0]  hdr_q [3];
  logic [7:0]  hdr_d [3];
  logic [15:0] word_pos;
  logic        ram_we;

  assign word_pos = (total_q - 16'd4) >> 1;

  always_comb begin
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    total_d  = total_q;
    dly0_d   = dly0_q;
    dly1_d   = dly1_q;
    pend_d   = pend_q;
    hdr_d    = hdr_q;
    ram_we   = 1'b0;
    if (cmd_i.accept_byte) begin
      if (total_q >= 16'd2) begin
        crc_d = crc_absorb(crc_q, dly0_q);
      end
      rx_crc_d = {rx_byte_i, dly1_q};
      dly0_d   = dly1_q;
      dly1_d   = rx_byte_i;
      if (total_q < 16'd3) begin
        hdr_d[total_q[1:0]] = rx_byte_i;
      end else if (total_q[0]) begin
        pend_d = rx_byte_i;
      end else begin
        ram_we = (word_pos < 16'(MAX_REGS));
      end
      if (total_q != BYTE_MAX) begin
        total_d = total_q + 16'd1;
      end
    end
    if (cmd_i.clear_frame) begin
      crc_d   = CRC_INIT;
      total_d = 16'd0;
      dly0_d  = 8'd0;
      dly1_d  = 8'd0;
      pend_d  = 8'd0;
      hdr_d   = '{default: 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      rx_crc_q <= 16'd0;
      total_q  <= 16'd0;
      dly0_q   <= 8'd0;
      dly1_q   <= 8'd0;
      pend_q   <= 8'd0;
      hdr_q    <= '{default: 8'd0};
    end else begin
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
      total_q  <= total_d;
      dly0_q   <= dly0_d;
      dly1_q   <= dly1_d;
      pend_q   <= pend_d;
      hdr_q    <= hdr_d;
    end
  end

  // register readout index
  logic [WORDS_W-1:0] idx_q, idx_d;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  logic [15:0] ram_rdata;

  rmrc_ram #(
    .WIDTH(16),
    .DEPTH(MAX_REGS)
  ) u_word_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(word_pos[AW-1:0]),
    .wdata_i({pend_q, rx_byte_i}),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // frame verdict, checked in priority order
  res_status_e verdict;
  logic        cfg_bad;

  assign cfg_bad = (slave_q == 8'd0) || (slave_q > MAX_SLAVE) ||
                   ((func_q != FC_HOLDING) && (func_q != FC_INPUT)) ||
                   (words_q == '0) || ({1'b0, words_q} > 8'(MAX_REGS));

  always_comb begin
    if (cfg_bad) begin
      verdict = RES_BAD_CFG;
    end else if (total_q < MIN_FRAME) begin
      verdict = RES_LENGTH;
    end else if (rx_crc_q != crc_q) begin
      verdict = RES_CRC;
    end else if (hdr_q[0] != slave_q) begin
      verdict = RES_ADDRESS;
    end else if (hdr_q[1] == (func_q | EXC_FLAG)) begin
      verdict = (total_q != MIN_FRAME) ? RES_LENGTH : RES_EXCEPTION;
    end else if (hdr_q[1] != func_q) begin
      verdict = RES_FUNCTION;
    end else if ((hdr_q[2] != {words_q, 1'b0}) ||
                 (total_q != ({8'd0, hdr_q[2]} + MIN_FRAME))) begin
      verdict = RES_LENGTH;
    end else begin
      verdict = RES_OK;
    end
  end

  // output register
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [7:0]  exc_q;
  logic [4:0]  index_q;
  logic [15:0] value_q;
  logic [5:0]  wtotal_q;
  logic        last_q;
  logic        idx_last;

  assign idx_last = (idx_q == (words_q - 7'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_status || cmd_i.load_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status) begin
      status_q <= verdict;
      exc_q    <= (verdict == RES_EXCEPTION) ? hdr_q[2] : 8'd0;
      index_q  <= 5'd0;
      value_q  <= 16'd0;
      wtotal_q <= 6'd0;
      last_q   <= 1'b1;
    end else if (cmd_i.load_word) begin
      status_q <= RES_OK;
      exc_q    <= 8'd0;
      index_q  <= idx_q[4:0];
      value_q  <= ram_rdata;
      wtotal_q <= words_q[5:0];
      last_q   <= idx_last;
    end
  end

  assign stat_o.is_ok    = (verdict == RES_OK);
  assign stat_o.idx_last = idx_last;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign exc_code_o   = exc_q;
  assign word_index_o = index_q;
  assign word_value_o = value_q;
  assign word_total_o = wtotal_q;
  assign last_o       = last_q;

endmodule

// ----- hdl/rmrc_ctrl.sv -----
// Controller: byte intake, frame-end verdict and register readout sequencing.
// Depends on rmrc_pkg.
module rmrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                frame_end_i,
  output logic                in_ready_o,
  input  rmrc_pkg::dp_stat_t  stat_i,
  output rmrc_pkg::ctrl_cmd_t cmd_o
);
  import rmrc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_READ = 4'b0100,
    ST_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept_byte = 1'b1;
          if (frame_end_i) begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (stat_i.is_ok) begin
          cmd_o.clear_frame = 1'b1;
          cmd_o.idx_clr     = 1'b1;
          state_d           = ST_READ;
        end else if (stat_i.out_free) begin
          cmd_o.load_status = 1'b1;
          cmd_o.clear_frame = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_word = 1'b1;
          if (stat_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/modbus_rtu_read_response_checker_core.sv -----
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// in       | in_valid_i/in_ready_o   | rx_byte_i, frame_end_i
// out      | out_valid_o/out_ready_i | status_o, exc_code_o, word_index_o,
//          |                         | word_value_o, word_total_o, last_o
// cfg      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One byte per cycle while no frame is being judged or read out.
// The cycle after the frame_end byte judges the frame and, on a failure, loads
// the status result; an ok frame then reads each register from the word store and loads it.
// A result waiting at the output holds the status or word load; the final
// result may wait there while the next frame's bytes flow in.
// Reset is asynchronous, active low; no clearing pass is needed.
//
// Top level of the Modbus RTU read-registers reply checker.
// Depends on rmrc_pkg, rmrc_ctrl, rmrc_dp, rmrc_ram and the assertion header.
`include "modbus_rtu_read_response_checker_core_assert.svh"

module modbus_rtu_read_response_checker_core #(
  parameter int unsigned MAX_REGS = rmrc_pkg::MAX_REGS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [rmrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rmrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // received bytes
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            frame_end_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [7:0]                      exc_code_o,
  output logic [4:0]                      word_index_o,
  output logic [15:0]                     word_value_o,
  output logic [5:0]                      word_total_o,
  output logic                            last_o
);
  import rmrc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer: owns the handshake on the byte side and the readout loop.
  rmrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .frame_end_i(frame_end_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: CRC, header capture, word store, verdict and output register.
  rmrc_dp #(
    .MAX_REGS(MAX_REGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (rx_byte_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .exc_code_o  (exc_code_o),
    .word_index_o(word_index_o),
    .word_value_o(word_value_o),
    .word_total_o(word_total_o),
    .last_o      (last_o)
  );

  // A word must never overwrite a result still waiting at the output.
  `RMRC_ASSERT_NOW(a_word_load_free, clk_i, rst_ni, cmd.load_word, stat.out_free)
  // A status result is a single, final result with no word count.
  `RMRC_ASSERT_NEXT(a_status_single, clk_i, rst_ni, cmd.load_status,
                    out_valid_o && last_o && (word_total_o == 6'd0))
  // Loading the final word reopens the byte side.
  `RMRC_ASSERT_NEXT(a_last_reopens, clk_i, rst_ni, cmd.load_word && stat.idx_last,
                    in_ready_o)
  // No byte is taken while the word store is being read.
  `RMRC_ASSERT_NOW(a_no_accept_in_read, clk_i, rst_ni, cmd.ram_rd, !in_ready_o)

endmodule

// ----- test/rmrc_reply_checker.sv -----
// Reply predictor and result checker for the Modbus RTU read-reply checker.
// Holds rmrc_tb_pkg (CRC-16 step used by predictor and frame builder).
// Depends on rmrc_pkg.
`timescale 1ns / 1ps

package rmrc_tb_pkg;
  import rmrc_pkg::*;

  // Reflected CRC-16, one input bit per iteration.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction
endpackage

module rmrc_reply_checker #(
  parameter int unsigned MAX_REGS = rmrc_pkg::MAX_REGS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rmrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            frame_end_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [2:0]                      status_i,
  input  logic [7:0]                      exc_code_i,
  input  logic [4:0]                      word_index_i,
  input  logic [15:0]                     word_value_i,
  input  logic [5:0]                      word_total_i,
  input  logic                            last_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  import rmrc_pkg::*;
  import rmrc_tb_pkg::*;

  typedef struct packed {
    res_status_e status;
    logic [7:0]  exc;
    logic [4:0]  idx;
    logic [15:0] value;
    logic [5:0]  total;
    logic        last;
  } reply_word_t;

  // register copies
  logic [7:0] slave_cfg;
  logic [7:0] func_cfg;
  logic [6:0] words_cfg;

  // frame state
  logic [15:0] crc_acc;
  logic [7:0]  crc_lag [2];
  logic [15:0] byte_cnt;
  logic [7:0]  hdr [3];
  logic [7:0]  hi_byte;
  logic [15:0] reg_file [MAX_REGS];

  reply_word_t expected_replies[$];
  int unsigned fails;

  task automatic restart_frame();
    crc_acc    = CRC_INIT;
    crc_lag[0] = '0;
    crc_lag[1] = '0;
    byte_cnt   = '0;
    hdr[0]     = '0;
    hdr[1]     = '0;
    hdr[2]     = '0;
    hi_byte    = '0;
  endtask

  task automatic absorb_rx_byte(input logic [7:0] b, input logic fin);
    logic [15:0] k;
    logic [15:0] n;
    logic [15:0] wire_crc;
    logic [15:0] w;
    res_status_e verdict;
    reply_word_t r;
    k = byte_cnt;
    // CRC trails the input by two bytes so the checksum itself stays out
    if (k >= 16'd2) crc_acc = crc16_step(crc_acc, crc_lag[0]);
    wire_crc   = {b, crc_lag[1]};
    crc_lag[0] = crc_lag[1];
    crc_lag[1] = b;
    if (k < 16'd3) begin
      hdr[k[1:0]] = b;
    end else if (k[0]) begin
      hi_byte = b;
    end else begin
      w = (k - 16'd4) >> 1;
      if (w < MAX_REGS) reg_file[w] = {hi_byte, b};
    end
    if (byte_cnt != BYTE_MAX) byte_cnt = byte_cnt + 16'd1;
    n = byte_cnt;
    if (!fin) return;

    r = '0;
    r.last = 1'b1;
    verdict = RES_OK;
    if (slave_cfg == 8'd0 || slave_cfg > MAX_SLAVE ||
        (func_cfg != FC_HOLDING && func_cfg != FC_INPUT) ||
        words_cfg == 7'd0 || words_cfg > MAX_REGS) begin
      verdict = RES_BAD_CFG;
    end else if (n < MIN_FRAME) begin
      verdict = RES_LENGTH;
    end else if (wire_crc != crc_acc) begin
      verdict = RES_CRC;
    end else if (hdr[0] != slave_cfg) begin
      verdict = RES_ADDRESS;
    end else if (hdr[1] == (func_cfg | EXC_FLAG)) begin
      if (n != MIN_FRAME) begin
        verdict = RES_LENGTH;
      end else begin
        verdict = RES_EXCEPTION;
        r.exc = hdr[2];
      end
    end else if (hdr[1] != func_cfg) begin
      verdict = RES_FUNCTION;
    end else if (int'(hdr[2]) != 2 * int'(words_cfg) ||
                 int'(n) != int'(hdr[2]) + int'(MIN_FRAME)) begin
      verdict = RES_LENGTH;
    end

    if (verdict == RES_OK) begin
      for (int i = 0; i < int'(words_cfg); i++) begin
        r        = '0;
        r.status = RES_OK;
        r.idx    = i[4:0];
        r.value  = reg_file[i];
        r.total  = 6'(words_cfg);
        r.last   = (i == int'(words_cfg) - 1);
        expected_replies.push_back(r);
      end
    end else begin
      r.status = verdict;
      expected_replies.push_back(r);
    end
    restart_frame();
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    reply_word_t want;
    if (expected_replies.size() == 0) begin
      fails++;
      $display("%0t: result mismatch, expected none, actual status %0d index %0d",
               $time, status_i, word_index_i);
      return;
    end
    want = expected_replies.pop_front();
    check_field("status", 16'(want.status), 16'(status_i));
    check_field("exc_code", 16'(want.exc), 16'(exc_code_i));
    check_field("word_index", 16'(want.idx), 16'(word_index_i));
    check_field("word_value", want.value, word_value_i);
    check_field("word_total", 16'(want.total), 16'(word_total_i));
    check_field("last", 16'(want.last), 16'(last_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_cfg = 8'd1;
      func_cfg  = FC_HOLDING;
      words_cfg = 7'd1;
      restart_frame();
      expected_replies.delete();
      fails = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SLAVE: slave_cfg = cfg_data_i;
          CFG_FUNC:  func_cfg  = cfg_data_i;
          CFG_WORDS: words_cfg = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_rx_byte(rx_byte_i, frame_end_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o <= expected_replies.size();
      errors_o  <= fails;
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the read-reply checker testbench: clock, reset, frame stimulus, verdict.
// Depends on rmrc_pkg, rmrc_tb_pkg, rmrc_reply_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
  import rmrc_pkg::*;
  import rmrc_tb_pkg::*;

  // Watchdog limit for a full run, heavy idling included.
  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned OVER_WORDS  = MAX_REGS_DEF + 1;
  localparam int unsigned BYTES_PER_SETTING = 6;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            rx_byte_i = '0;
  logic                  frame_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            status_o;
  logic [7:0]            exc_code_o;
  logic [4:0]            word_index_o;
  logic [15:0]           word_value_o;
  logic [5:0]            word_total_o;
  logic                  last_o;

  int unsigned reply_pending;
  int unsigned reply_errors;

  // idle/stall odds in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;

  // shadow of the programmed registers, used to build matching frames
  logic [7:0] cur_slave = 8'd1;
  logic [7:0] cur_func  = FC_HOLDING;
  logic [6:0] cur_words = 7'd1;
  logic       cfg_ok    = 1'b1;

  logic [7:0] byte_q[$];

  modbus_rtu_read_response_checker_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .exc_code_o   (exc_code_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .word_total_o (word_total_o),
    .last_o       (last_o)
  );

  rmrc_reply_checker reply_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_end_i  (frame_end_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .exc_code_i   (exc_code_o),
    .word_index_i (word_index_o),
    .word_value_i (word_value_o),
    .word_total_i (word_total_o),
    .last_i       (last_o),
    .pending_o    (reply_pending),
    .errors_o     (reply_errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: ready drops at random with the current stall odds.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[modbus_rtu_read_response_checker_core] ERROR");
    $finish;
  end

  // One byte request. Valid stays high across back-to-back requests; it is only
  // lowered when an idle gap is taken, and then garbage sits on the payload.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      rx_byte_i   <= 8'($urandom);
      frame_end_i <= 1'($urandom);
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (byte_q[i]) send_byte(byte_q[i], i == byte_q.size() - 1);
  endtask

  // Checksum goes out low byte first.
  task automatic append_crc();
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (byte_q[i]) crc = crc16_step(crc, byte_q[i]);
    byte_q.push_back(crc[7:0]);
    byte_q.push_back(crc[15:8]);
  endtask

  task automatic build_reply(input int unsigned words, input logic [7:0] slave,
                             input logic [7:0] func, input logic [7:0] count);
    byte_q = {};
    byte_q.push_back(slave);
    byte_q.push_back(func);
    byte_q.push_back(count);
    repeat (2 * words) byte_q.push_back(8'($urandom));
    append_crc();
  endtask

  task automatic build_exception(input logic [7:0] slave, input logic [7:0] func,
                                 input logic [7:0] code, input int unsigned extra);
    byte_q = {};
    byte_q.push_back(slave);
    byte_q.push_back(func);
    byte_q.push_back(code);
    repeat (extra) byte_q.push_back(8'($urandom));
    append_crc();
  endtask

  task automatic build_noise(input int unsigned len);
    byte_q = {};
    repeat (len) byte_q.push_back(8'($urandom));
  endtask

  // Stop sending and wait until every predicted result has been taken,
  // then wait out SETTLE for the block to settle back to idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reply_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [7:0] slave, input logic [7:0] func,
                               input logic [7:0] words);
    drain();
    write_reg(CFG_SLAVE, slave);
    write_reg(CFG_FUNC, func);
    write_reg(CFG_WORDS, words);
    cur_slave = slave;
    cur_func  = func;
    cur_words = words[6:0];
    cfg_ok = slave != 8'd0 && slave <= MAX_SLAVE &&
             (func == FC_HOLDING || func == FC_INPUT) &&
             words[6:0] != 7'd0 && words[6:0] <= MAX_REGS_DEF;
  endtask

  // Mostly valid settings, word counts weighted toward small replies.
  task automatic random_setting();
    logic [7:0]  s;
    logic [7:0]  f;
    logic [7:0]  w;
    int unsigned pick;
    if ($urandom_range(4) != 0) begin
      s = 8'($urandom_range(1, 247));
      f = $urandom_range(1) ? FC_INPUT : FC_HOLDING;
      pick = $urandom_range(9);
      if (pick < 7)      w = 8'($urandom_range(1, 8));
      else if (pick < 9) w = 8'($urandom_range(9, 31));
      else               w = 8'(MAX_REGS_DEF);
    end else begin
      s = 8'($urandom);
      f = 8'($urandom);
      w = 8'($urandom);
    end
    apply_setting(s, f, w);
  endtask

  // Mostly well-formed replies with random contents; the rest is one fault each.
  task automatic random_frame();
    int unsigned pick;
    int unsigned nw;
    int unsigned pos;
    pick = $urandom_range(99);
    nw = cfg_ok ? int'(cur_words) : $urandom_range(1, 8);
    if (pick < 55) begin
      build_reply(nw, cur_slave, cur_func, 8'(2 * nw));
    end else if (pick < 65) begin
      build_exception(cur_slave, cur_func | EXC_FLAG, 8'($urandom), 0);
    end else if (pick < 70) begin
      build_exception(cur_slave, cur_func | EXC_FLAG, 8'($urandom), $urandom_range(1, 3));
    end else if (pick < 75) begin
      // single bit hit anywhere, checksum included
      build_reply(nw, cur_slave, cur_func, 8'(2 * nw));
      pos = $urandom_range(byte_q.size() - 1);
      byte_q[pos] = byte_q[pos] ^ (8'd1 << $urandom_range(7));
    end else if (pick < 80) begin
      build_reply(nw, cur_slave ^ 8'($urandom_range(1, 255)), cur_func, 8'(2 * nw));
    end else if (pick < 85) begin
      build_reply(nw, cur_slave, 8'($urandom), 8'(2 * nw));
    end else if (pick < 90) begin
      // count field or payload size off
      if ($urandom_range(1))
        build_reply(nw, cur_slave, cur_func, 8'($urandom));
      else if (nw > 1 && $urandom_range(1))
        build_reply(nw - 1, cur_slave, cur_func, 8'(2 * nw));
      else
        build_reply(nw + 1, cur_slave, cur_func, 8'(2 * nw));
    end else if (pick < 95) begin
      build_noise($urandom_range(1, 4));
    end else begin
      build_noise($urandom_range(1, 12));
      if ($urandom_range(1)) byte_q[0] = cur_slave;
    end
    send_frame();
  endtask

  initial begin : stimulus
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    int unsigned target;
    idle_tab  = '{0, 72, 0, 17};
    stall_tab = '{0, 0, 72, 17};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, no idling ----
    // reset settings: slave 1, holding registers, one word
    build_reply(1, 8'd1, FC_HOLDING, 8'd2);
    send_frame();                                    // good reply
    build_noise(1);
    send_frame();                                    // one-byte frame: too short
    build_exception(8'd1, FC_HOLDING | EXC_FLAG, 8'h02, 0);
    send_frame();                                    // exception reply
    build_exception(8'd1, FC_HOLDING | EXC_FLAG, 8'hFF, 2);
    send_frame();                                    // exception, wrong length
    build_reply(1, 8'd1, FC_HOLDING, 8'd2);
    byte_q[3] = byte_q[3] ^ 8'h80;
    send_frame();                                    // checksum error
    build_reply(1, 8'd0, FC_HOLDING, 8'd2);
    send_frame();                                    // wrong slave
    build_reply(1, 8'd1, FC_INPUT, 8'd2);
    send_frame();                                    // wrong function
    build_reply(1, 8'd1, FC_HOLDING, 8'd4);
    send_frame();                                    // byte count disagrees
    build_reply(2, 8'd1, FC_HOLDING, 8'd2);
    send_frame();                                    // frame longer than count

    // top of the valid ranges
    apply_setting(MAX_SLAVE, FC_INPUT, 8'(MAX_REGS_DEF));
    build_reply(MAX_REGS_DEF, MAX_SLAVE, FC_INPUT, 8'(2 * MAX_REGS_DEF));
    send_frame();
    build_exception(MAX_SLAVE, FC_INPUT | EXC_FLAG, 8'h00, 0);
    send_frame();

    // bad settings, one frame each
    apply_setting(8'd255, FC_INPUT, 8'(MAX_REGS_DEF));
    random_frame();
    apply_setting(8'd0, FC_HOLDING, 8'd1);
    random_frame();
    apply_setting(8'd1, 8'd0, 8'd1);
    random_frame();
    apply_setting(8'd1, 8'd255, 8'd1);
    random_frame();
    apply_setting(8'd1, FC_HOLDING, 8'd0);
    random_frame();
    apply_setting(8'd1, FC_HOLDING, 8'd33);
    random_frame();
    apply_setting(8'd1, FC_HOLDING, 8'hFF);          // 127 words after masking
    random_frame();
    apply_setting(8'd1, FC_HOLDING, 8'h82);          // bit 7 dropped: two words
    build_reply(2, 8'd1, FC_HOLDING, 8'd4);
    send_frame();

    // Oversized reply: the words past the store are dropped; checksum is kept
    // right so the length check decides.
    build_reply(OVER_WORDS, cur_slave, cur_func, 8'(2 * cur_words));
    send_frame();

    // ---- random part: four idling phases, two settings each ----
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      repeat (2) begin
        random_setting();
        target = bytes_sent + BYTES_PER_SETTING;
        while (bytes_sent < target) begin
          random_frame();
          // now and then hold off until the readout has fully drained
          if ($urandom_range(7) == 0) drain();
        end
      end
    end

    drain();
    if (reply_errors == 0 && reply_pending == 0) begin
      $display("[modbus_rtu_read_response_checker_core] OK");
    end else begin
      $display("[modbus_rtu_read_response_checker_core] ERROR");
    end
    $finish;
  end

endmodule
